// ===== design/drxm_pkg.sv =====
// Shared types and constants of the DRAM bank region XOR mapper.
package drxm_pkg;

  localparam int CMD_W    = 2;
  localparam int REGION_W = 2;
  localparam int SLOT_W   = 3;
  localparam int DATA_W   = 64;
  localparam int BANK_W   = 10;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 4;
  localparam int RIU_W    = 3;
  localparam int LBB_W    = 4;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int Q_CW     = 3;

  // Command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_SEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_FN  = 2'd2;

  // Status codes on the result channel
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MULTI_MATCH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGIONS_IN_USE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_BANK_BITS = 1'd1;

  // Operation decided by the front end
  typedef enum logic [1:0] {
    OP_NOP,
    OP_TRANSLATE,
    OP_WRITE_SEL,
    OP_WRITE_FN
  } op_t;

  // Queue entry: data is the address for a translate, the mask for a write
  typedef struct packed {
    op_t                 op;
    logic [REGION_W-1:0] region;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   data;
    logic                parity;
    logic                enable;
  } q_entry_t;

endpackage

// ===== design/drxm_in_if.sv =====
// Request channel of the bank mapper.
interface drxm_in_if;
  logic                          valid;
  logic                          ready;
  logic [drxm_pkg::CMD_W-1:0]    command;
  logic [drxm_pkg::REGION_W-1:0] region_index;
  logic [drxm_pkg::SLOT_W-1:0]   slot_index;
  logic [drxm_pkg::DATA_W-1:0]   bit_mask;
  logic                          expected_parity;
  logic                          slot_enable;
  logic [drxm_pkg::DATA_W-1:0]   address;

  modport source (
    output valid, command, region_index, slot_index, bit_mask,
           expected_parity, slot_enable, address,
    input  ready
  );
  modport sink (
    input  valid, command, region_index, slot_index, bit_mask,
           expected_parity, slot_enable, address,
    output ready
  );
endinterface

// ===== design/drxm_out_if.sv =====
// Result channel of the bank mapper.
interface drxm_out_if;
  logic                          valid;
  logic                          ready;
  logic [drxm_pkg::BANK_W-1:0]   bank;
  logic [drxm_pkg::STATUS_W-1:0] status;

  modport source (output valid, bank, status, input ready);
  modport sink (input valid, bank, status, output ready);
endinterface

// ===== design/dram_bank_region_xor_mapper_unit.sv =====
// Top level of the DRAM bank region XOR mapper.
//
//  channel | direction | handshake          | payload
//  in_ch   | sink      | valid / ready      | command, region, slot, mask, parity, enable, address
//  out_ch  | source    | valid / ready      | bank, status
//  cfg_*   | sink      | cfg_we, no stall   | cfg_index, cfg_wdata
//
// One request per cycle while the queue has room and out_ch.ready does not hold the
// pipeline; an accepted request passes the queue, the match stage and then the output register.
// Synchronous active-low reset clears the queue, the pipeline valids and the
// table valid bits; regions_in_use returns to 1 and local_bank_bits to 0.
// A four-entry queue decouples the front end from the back end, so requests keep
// being accepted while the output register waits on out_ch.ready, until the queue is full.
module dram_bank_region_xor_mapper_unit #(
  parameter int NUM_REGIONS          = 4,
  parameter int SELECTORS_PER_REGION = 8,
  parameter int FUNCS_PER_REGION     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  drxm_in_if.sink                        in_ch,
  drxm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [drxm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drxm_pkg::CFG_W-1:0]     cfg_wdata
);
  import drxm_pkg::*;

  logic     q_ready;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head_entry;

  // Classify incoming requests
  drxm_front #(
    .NUM_REGIONS          (NUM_REGIONS),
    .SELECTORS_PER_REGION (SELECTORS_PER_REGION),
    .FUNCS_PER_REGION     (FUNCS_PER_REGION)
  ) u_front (
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple front and back
  drxm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Carry out writes and translations
  drxm_back #(
    .NUM_REGIONS          (NUM_REGIONS),
    .SELECTORS_PER_REGION (SELECTORS_PER_REGION),
    .FUNCS_PER_REGION     (FUNCS_PER_REGION)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== design/drxm_front.sv =====
// Front end: accept requests, classify them and push them into the queue.
module drxm_front #(
  parameter int NUM_REGIONS          = 4,
  parameter int SELECTORS_PER_REGION = 8,
  parameter int FUNCS_PER_REGION     = 8
) (
  drxm_in_if.sink             in_ch,
  input  logic                q_ready,
  output logic                push,
  output drxm_pkg::q_entry_t  push_entry
);
  import drxm_pkg::*;

  logic region_ok;
  logic sel_slot_ok;
  logic fn_slot_ok;

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;

  // Range checks for table writes
  assign region_ok   = int'(in_ch.region_index) < NUM_REGIONS;
  assign sel_slot_ok = int'(in_ch.slot_index) < SELECTORS_PER_REGION;
  assign fn_slot_ok  = int'(in_ch.slot_index) < FUNCS_PER_REGION;

  // Decode the command; out-of-range writes become no-ops
  always_comb begin
    push_entry.region = in_ch.region_index;
    push_entry.slot   = in_ch.slot_index;
    push_entry.parity = in_ch.expected_parity;
    push_entry.enable = in_ch.slot_enable;
    push_entry.data   = in_ch.bit_mask;
    push_entry.op     = OP_NOP;
    unique case (in_ch.command)
      CMD_TRANSLATE: begin
        push_entry.op   = OP_TRANSLATE;
        push_entry.data = in_ch.address;
      end
      CMD_WRITE_SEL: begin
        if (region_ok && sel_slot_ok) begin
          push_entry.op = OP_WRITE_SEL;
        end
      end
      CMD_WRITE_FN: begin
        if (region_ok && fn_slot_ok) begin
          push_entry.op = OP_WRITE_FN;
        end
      end
      default: begin
        push_entry.op = OP_NOP;
      end
    endcase
  end

endmodule

// ===== design/drxm_queue.sv =====
// Short request queue between front end and back end.
module drxm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  drxm_pkg::q_entry_t  push_entry,
  output logic                q_ready,
  input  logic                pop,
  output logic                head_valid,
  output drxm_pkg::q_entry_t  head_entry
);
  import drxm_pkg::*;

  q_entry_t          entries_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r;
  logic [Q_CW-1:0]   count_nxt;

  assign q_ready    = count_r != Q_CW'(Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = entries_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== design/drxm_back.sv =====
// Back end: table writes, parity matching and bank assembly.
module drxm_back #(
  parameter int NUM_REGIONS          = 4,
  parameter int SELECTORS_PER_REGION = 8,
  parameter int FUNCS_PER_REGION     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [drxm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drxm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              head_valid,
  input  drxm_pkg::q_entry_t                head_entry,
  output logic                              pop,
  drxm_out_if.source                        out_ch
);
  import drxm_pkg::*;

  localparam int SEL_SLOTS = NUM_REGIONS * SELECTORS_PER_REGION;
  localparam int FN_SLOTS  = NUM_REGIONS * FUNCS_PER_REGION;
  localparam int SIW = (SEL_SLOTS > 1) ? $clog2(SEL_SLOTS) : 1;
  localparam int FIW = (FN_SLOTS > 1) ? $clog2(FN_SLOTS) : 1;
  localparam int RW  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  // Configuration registers
  logic [RIU_W-1:0] riu_r;
  logic [LBB_W-1:0] lbb_r;

  // Mapping table
  logic [DATA_W-1:0]    sel_mask_r  [SEL_SLOTS];
  logic                 sel_par_r   [SEL_SLOTS];
  logic [SEL_SLOTS-1:0] sel_valid_r;
  logic [DATA_W-1:0]    fn_mask_r   [FN_SLOTS];
  logic [FN_SLOTS-1:0]  fn_valid_r;

  logic [SIW-1:0] sel_idx;
  logic [FIW-1:0] fn_idx;

  // Match stage
  logic                        s1_valid_r;
  op_t                         s1_op_r;
  logic [NUM_REGIONS-1:0]      s1_match_r;
  logic [FUNCS_PER_REGION-1:0] s1_fn_r [NUM_REGIONS];
  logic [NUM_REGIONS-1:0]      match_nxt;
  logic [FUNCS_PER_REGION-1:0] fn_nxt [NUM_REGIONS];
  logic                        s1_adv;

  // Output stage
  logic                 out_valid_r;
  logic [BANK_W-1:0]    bank_r;
  logic [STATUS_W-1:0]  status_r;
  logic [BANK_W-1:0]    bank_nxt;
  logic [STATUS_W-1:0]  status_nxt;

  // Pipeline flow control
  assign s1_adv = !out_valid_r || out_ch.ready;
  assign pop    = head_valid && (!s1_valid_r || s1_adv);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.bank   = bank_r;
  assign out_ch.status = status_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      riu_r <= RIU_W'(1);
      lbb_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGIONS_IN_USE:  riu_r <= cfg_wdata[RIU_W-1:0];
        CFG_LOCAL_BANK_BITS: lbb_r <= cfg_wdata[LBB_W-1:0];
        default: ;
      endcase
    end
  end

  // Flat slot indexes for writes
  assign sel_idx = SIW'(int'(head_entry.region) * SELECTORS_PER_REGION
                        + int'(head_entry.slot));
  assign fn_idx  = FIW'(int'(head_entry.region) * FUNCS_PER_REGION
                        + int'(head_entry.slot));

  // Valid bits of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= '0;
      fn_valid_r  <= '0;
    end else if (pop) begin
      if (head_entry.op == OP_WRITE_SEL) begin
        sel_valid_r[sel_idx] <= head_entry.enable;
      end
      if (head_entry.op == OP_WRITE_FN) begin
        fn_valid_r[fn_idx] <= head_entry.enable;
      end
    end
  end

  // Masks and parities of the table
  always_ff @(posedge clk) begin
    if (pop && head_entry.op == OP_WRITE_SEL) begin
      sel_mask_r[sel_idx] <= head_entry.data;
      sel_par_r[sel_idx]  <= head_entry.parity;
    end
    if (pop && head_entry.op == OP_WRITE_FN) begin
      fn_mask_r[fn_idx] <= head_entry.data;
    end
  end

  // Evaluate every selector and function parity against the address
  always_comb begin
    logic mis;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      mis = 1'b0;
      for (int s = 0; s < SELECTORS_PER_REGION; s++) begin
        mis = mis | (sel_valid_r[r*SELECTORS_PER_REGION+s] &&
              ((^(head_entry.data & sel_mask_r[r*SELECTORS_PER_REGION+s]))
               != sel_par_r[r*SELECTORS_PER_REGION+s]));
      end
      match_nxt[r] = !mis && (r < int'(riu_r));
      for (int f = 0; f < FUNCS_PER_REGION; f++) begin
        fn_nxt[r][f] = fn_valid_r[r*FUNCS_PER_REGION+f] &&
                       (^(head_entry.data & fn_mask_r[r*FUNCS_PER_REGION+f]));
      end
    end
  end

  // Match stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pop) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r    <= head_entry.op;
      s1_match_r <= match_nxt;
      s1_fn_r    <= fn_nxt;
    end
  end

  // Resolve the region and assemble the bank number
  always_comb begin
    logic [RW-1:0]                      found;
    logic                               multi;
    logic [FUNCS_PER_REGION+BANK_W-1:0] local_ext;
    logic [BANK_W-1:0]                  region_sh;
    found = '0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (s1_match_r[r]) begin
        found = RW'(r);
      end
    end
    multi      = |(s1_match_r & (s1_match_r - 1'b1));
    local_ext  = {{BANK_W{1'b0}}, s1_fn_r[found]};
    region_sh  = BANK_W'(found) << lbb_r;
    bank_nxt   = '0;
    status_nxt = ST_OK;
    if (s1_op_r == OP_TRANSLATE) begin
      if (s1_match_r == '0) begin
        status_nxt = ST_NO_MATCH;
      end else if (multi) begin
        status_nxt = ST_MULTI_MATCH;
      end else begin
        bank_nxt = region_sh | local_ext[BANK_W-1:0];
      end
    end
  end

  // Output register; hold while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      bank_r   <= bank_nxt;
      status_r <= status_nxt;
    end
  end

  a_err_zero_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> (bank_r == '0))
    else $error("error result carries a bank number");

  a_sel_write: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_entry.op == OP_WRITE_SEL) |=>
      (sel_valid_r[$past(sel_idx)] == $past(head_entry.enable)))
    else $error("selector valid bit not updated by write");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && !pop) |=> (out_valid_r && !s1_valid_r))
    else $error("match stage lost a request");

endmodule
